@@ rtl/clc_pkg.sv @@
// Shared types, codes and constants of the combination lock controller.
package clc_pkg;

  // Default number of digits in one code entry.
  localparam int unsigned CodeLenDef = 5;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_ROTATE_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_TICKS  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRIALS   = 2'd3;

  localparam logic [15:0] RotateTicksRst = 16'd15;
  localparam logic [15:0] HoldTicksRst   = 16'd3;
  localparam logic [15:0] AlarmTicksRst  = 16'd60;
  localparam logic [3:0]  MaxTrialsRst   = 4'd3;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command bytes.
  localparam logic [7:0] CMD_OPEN_DOOR   = 8'h30;
  localparam logic [7:0] CMD_CHANGE_CODE = 8'h40;
  localparam logic [7:0] CMD_WRONG_CODE  = 8'h50;

  // Reply codes.
  localparam logic [2:0] REPLY_NONE    = 3'd0;
  localparam logic [2:0] REPLY_DIFFER  = 3'd1;
  localparam logic [2:0] REPLY_SAME    = 3'd2;
  localparam logic [2:0] REPLY_MATCH   = 3'd3;
  localparam logic [2:0] REPLY_NOMATCH = 3'd4;

  // Motor drive codes.
  localparam logic [1:0] DRIVE_STOP = 2'd0;
  localparam logic [1:0] DRIVE_CW   = 2'd1;
  localparam logic [1:0] DRIVE_CCW  = 2'd2;

  // Reported mode codes.
  localparam logic [2:0] LOCK_FIRST        = 3'd0;
  localparam logic [2:0] LOCK_SECOND       = 3'd1;
  localparam logic [2:0] LOCK_VERIFY       = 3'd2;
  localparam logic [2:0] LOCK_OPTION       = 3'd3;
  localparam logic [2:0] LOCK_ALARM_OPTION = 3'd4;
  localparam logic [2:0] LOCK_MOTOR        = 3'd5;
  localparam logic [2:0] LOCK_ALARM        = 3'd6;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] reply_code;
    logic [1:0] motor_drive;
    logic       alarm_on;
    logic [2:0] lock_mode;
  } out_item_t;

endpackage

@@ rtl/clc_code_ram.sv @@
// Code storage memory: one write port, one registered read port, write-to-read forwarding.
module clc_code_ram #(
  parameter int unsigned Depth = 2 * clc_pkg::CodeLenDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q       <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // The memory returns old data on a same-address collision, so the write wins here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

@@ rtl/combination_lock_controller_unit.sv @@
// Top level of the combination lock controller: control sequencer, code memory and output buffer.
//
// Usage: each input item is either a received byte (a code digit or a command) or one
// timer tick. Every accepted item produces exactly one result item carrying the reply
// code, the motor drive, the buzzer state and the mode reached after that item.
// A new code is entered twice and kept only when both entries agree; later entries are
// checked against it, and repeated wrong entries lead to an alarm that lasts a set
// number of ticks. A correct entry allows a door-open command (motor forward, hold,
// back, stop) or a code change.
// Both channels use valid/ready. The result of an item is registered in the output buffer
// when the item is accepted. The block takes one item per cycle while the output buffer
// has room: the digit for the next item is fetched from the code memory during the current
// one, at the address the next state selects, so the registered read never stalls the input.
// A two-entry output buffer decouples the sides: when the receiver stalls, one more item
// is still taken, and input ready drops only while both entries are full.
// Reset clears the mode, counters and output buffer; the code memory itself is not
// cleared and holds no code until one has been entered. The configuration port writes
// one register per cycle with no handshake and should be used only while idle.
module combination_lock_controller_unit #(
  parameter int unsigned CODE_LEN = clc_pkg::CodeLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  clc_pkg::in_item_t            in_data_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output clc_pkg::out_item_t           out_data_o,

  input  logic                         cfg_we_i,
  input  logic [clc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [clc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int unsigned Depth = 2 * CODE_LEN;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(CODE_LEN - 1);
  localparam logic [AddrW-1:0] BankBase = AddrW'(CODE_LEN);

  typedef enum logic [6:0] {
    ModeFirst       = 7'b0000001,
    ModeSecond      = 7'b0000010,
    ModeVerify      = 7'b0000100,
    ModeOption      = 7'b0001000,
    ModeAlarmOption = 7'b0010000,
    ModeMotor       = 7'b0100000,
    ModeAlarm       = 7'b1000000
  } mode_e;

  // Configuration registers.
  logic [15:0] rotate_ticks_q, hold_ticks_q, alarm_ticks_q;
  logic [3:0]  max_trials_q;

  // Sequencer state. The code memory holds two banks: saved_bank_q selects the
  // saved code, the other bank receives the candidate. Saving a code flips the bank.
  mode_e       mode_q, mode_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic        mism_q, mism_d;
  logic [3:0]  trial_q, trial_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] ticks_q, ticks_d;
  logic        saved_bank_q, saved_bank_d;

  // Output buffer: head entry and skid entry.
  clc_pkg::out_item_t head_q, head_d, skid_q, skid_d;
  logic        head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;

  logic        in_acc;
  logic        pop;
  logic [7:0]  rd_data;
  logic        mem_we;
  logic [AddrW-1:0] waddr, raddr;
  logic        digit_bad, mm, idx_last, verify_clr, ticks_done, rd_bank;
  logic [IdxW-1:0] idx_step;
  logic [15:0] tick_inc, dur;
  logic [3:0]  trial_inc;
  logic [2:0]  reply;
  clc_pkg::out_item_t res;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pop        = head_valid_q && out_ready_i;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_ticks_q <= clc_pkg::RotateTicksRst;
      hold_ticks_q   <= clc_pkg::HoldTicksRst;
      alarm_ticks_q  <= clc_pkg::AlarmTicksRst;
      max_trials_q   <= clc_pkg::MaxTrialsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clc_pkg::CFG_ROTATE_TICKS: rotate_ticks_q <= cfg_wdata_i;
        clc_pkg::CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_wdata_i;
        clc_pkg::CFG_ALARM_TICKS:  alarm_ticks_q  <= cfg_wdata_i;
        clc_pkg::CFG_MAX_TRIALS:   max_trials_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign digit_bad  = rd_data != in_data_i.data_byte;
  assign mm         = mism_q | digit_bad;
  assign idx_last   = idx_q == LastIdx;
  assign idx_step   = idx_last ? '0 : idx_q + 1'b1;
  assign tick_inc   = ticks_q + 16'd1;
  assign dur        = (phase_q == 2'd1) ? hold_ticks_q : rotate_ticks_q;
  assign trial_inc  = trial_q + 4'd1;

  always_comb begin
    mode_d       = mode_q;
    idx_d        = idx_q;
    mism_d       = mism_q;
    trial_d      = trial_q;
    phase_d      = phase_q;
    ticks_d      = ticks_q;
    saved_bank_d = saved_bank_q;
    reply        = clc_pkg::REPLY_NONE;
    mem_we       = 1'b0;
    verify_clr   = 1'b0;
    ticks_done   = 1'b0;

    if (in_acc) begin
      if (in_data_i.operation == clc_pkg::OP_BYTE) begin
        unique case (mode_q)
          ModeFirst: begin
            mem_we = 1'b1;
            idx_d  = idx_step;
            if (idx_last) begin
              mode_d = ModeSecond;
              mism_d = 1'b0;
            end
          end
          ModeSecond: begin
            idx_d  = idx_step;
            mism_d = mm;
            if (idx_last) begin
              if (mm) begin
                reply  = clc_pkg::REPLY_DIFFER;
                mode_d = ModeFirst;
                mism_d = 1'b0;
              end else begin
                reply        = clc_pkg::REPLY_SAME;
                saved_bank_d = !saved_bank_q;
                mode_d       = ModeVerify;
                verify_clr   = 1'b1;
              end
            end
          end
          ModeVerify: begin
            idx_d  = idx_step;
            mism_d = mm;
            if (idx_last) begin
              if (mm) begin
                reply   = clc_pkg::REPLY_NOMATCH;
                mism_d  = 1'b0;
                trial_d = trial_inc;
                if (trial_inc >= max_trials_q) begin
                  mode_d = ModeAlarmOption;
                end
              end else begin
                reply  = clc_pkg::REPLY_MATCH;
                mode_d = ModeOption;
              end
            end
          end
          ModeOption: begin
            verify_clr = 1'b1;
            if (in_data_i.data_byte == clc_pkg::CMD_OPEN_DOOR) begin
              mode_d = ModeMotor;
            end else if (in_data_i.data_byte == clc_pkg::CMD_CHANGE_CODE) begin
              mode_d = ModeFirst;
            end else begin
              mode_d = ModeVerify;
            end
          end
          ModeAlarmOption: begin
            verify_clr = 1'b1;
            if (in_data_i.data_byte == clc_pkg::CMD_WRONG_CODE) begin
              mode_d = ModeAlarm;
            end else begin
              mode_d = ModeVerify;
            end
          end
          ModeMotor, ModeAlarm: ;
          default: begin
            mode_d = ModeFirst;
            idx_d  = '0;
            mism_d = 1'b0;
          end
        endcase
      end else begin
        // Timer tick: only the motor and alarm phases count.
        if (mode_q == ModeMotor) begin
          ticks_d = tick_inc;
          if (tick_inc >= dur) begin
            ticks_d = '0;
            if (phase_q[1]) begin
              mode_d     = ModeVerify;
              verify_clr = 1'b1;
            end else begin
              phase_d = phase_q + 2'd1;
            end
          end
        end else if (mode_q == ModeAlarm) begin
          ticks_d    = tick_inc;
          ticks_done = tick_inc >= alarm_ticks_q;
          if (ticks_done) begin
            mode_d     = ModeVerify;
            verify_clr = 1'b1;
          end
        end
      end
    end

    if (verify_clr) begin
      idx_d   = '0;
      mism_d  = 1'b0;
      trial_d = '0;
      phase_d = '0;
      ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeFirst;
      idx_q        <= '0;
      mism_q       <= 1'b0;
      trial_q      <= '0;
      phase_q      <= '0;
      ticks_q      <= '0;
      saved_bank_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      idx_q        <= idx_d;
      mism_q       <= mism_d;
      trial_q      <= trial_d;
      phase_q      <= phase_d;
      ticks_q      <= ticks_d;
      saved_bank_q <= saved_bank_d;
    end
  end

  // ---------------------------------------------------------------- code memory
  // Candidate digits go to the free bank. The read address follows the next state,
  // so the digit the next item compares against is ready when it arrives.
  assign waddr   = saved_bank_q ? AddrW'(idx_q) : BankBase + AddrW'(idx_q);
  assign rd_bank = (mode_d == ModeSecond) ? !saved_bank_d : saved_bank_d;
  assign raddr   = rd_bank ? BankBase + AddrW'(idx_d) : AddrW'(idx_d);

  clc_code_ram #(
    .Depth(Depth)
  ) u_code_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.data_byte),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    res.reply_code  = reply;
    res.motor_drive = clc_pkg::DRIVE_STOP;
    res.alarm_on    = mode_d == ModeAlarm;
    if (mode_d == ModeMotor) begin
      if (phase_d == 2'd0) begin
        res.motor_drive = clc_pkg::DRIVE_CW;
      end else if (phase_d == 2'd2) begin
        res.motor_drive = clc_pkg::DRIVE_CCW;
      end
    end
    unique case (mode_d)
      ModeFirst:       res.lock_mode = clc_pkg::LOCK_FIRST;
      ModeSecond:      res.lock_mode = clc_pkg::LOCK_SECOND;
      ModeVerify:      res.lock_mode = clc_pkg::LOCK_VERIFY;
      ModeOption:      res.lock_mode = clc_pkg::LOCK_OPTION;
      ModeAlarmOption: res.lock_mode = clc_pkg::LOCK_ALARM_OPTION;
      ModeMotor:       res.lock_mode = clc_pkg::LOCK_MOTOR;
      ModeAlarm:       res.lock_mode = clc_pkg::LOCK_ALARM;
      default:         res.lock_mode = clc_pkg::LOCK_FIRST;
    endcase
  end

  // ---------------------------------------------------------------- output buffer
  // A new item can only arrive while the skid entry is empty.
  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
    if (in_acc) begin
      if (!head_valid_d) begin
        head_d       = res;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

endmodule

@@ tb/sv/combination_lock_controller_unit_tb.sv @@
// Self-checking testbench of the combination lock controller: keypad scripts, lockouts and timers.
module combination_lock_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeLen   = clc_pkg::CodeLenDef;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 80;

  // One row of the opening script. Rows with pinned set carry a result typed in by hand;
  // all other rows take the result that the lock predictor works out.
  typedef struct packed {
    clc_pkg::in_item_t  stim;
    logic               pinned;
    clc_pkg::out_item_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                         in_valid;
  logic                         in_ready;
  clc_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_ready;
  clc_pkg::out_item_t           out_data;
  logic                         cfg_we;
  logic [clc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [clc_pkg::CfgDataW-1:0] cfg_wdata;

  // Predicted lock state, advanced once per accepted item.
  logic [2:0]  lk_mode;
  logic [3:0]  lk_digit;
  logic [7:0]  lk_entry [CodeLen];
  logic [7:0]  lk_code [CodeLen];
  logic        lk_mismatch;
  logic [3:0]  lk_tries;
  logic [1:0]  lk_motor_phase;
  logic [15:0] lk_phase_ticks;

  // Predicted register contents.
  logic [15:0] set_rotate;
  logic [15:0] set_hold;
  logic [15:0] set_alarm;
  logic [3:0]  set_max_tries;

  // Code that the simulated user is keying in for the current entry.
  logic [7:0] keyed_code [CodeLen];

  clc_pkg::out_item_t pending_replies [$];
  clc_pkg::out_item_t oldest;
  script_row_t        opening [$];

  int unsigned errs;
  int unsigned sent;
  int unsigned counted;
  int unsigned results_seen;
  int unsigned door_runs;
  int unsigned alarms;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_due;

  combination_lock_controller_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lock predictor
  // ---------------------------------------------------------------------------

  function automatic void lk_to_verify();
    lk_mode        = clc_pkg::LOCK_VERIFY;
    lk_digit       = 4'd0;
    lk_mismatch    = 1'b0;
    lk_tries       = 4'd0;
    lk_motor_phase = 2'd0;
    lk_phase_ticks = 16'd0;
  endfunction

  // Takes one digit of an entry, either storing it or comparing it with the candidate
  // or the saved code. Returns 1 on the digit that completes the entry.
  function automatic bit lk_take_digit(logic [7:0] b, bit keep, bit vs_code);
    logic [7:0] stored;
    if (lk_digit < CodeLen) begin
      stored = vs_code ? lk_code[lk_digit] : lk_entry[lk_digit];
      if (keep) begin
        lk_entry[lk_digit] = b;
      end else if (stored != b) begin
        lk_mismatch = 1'b1;
      end
    end
    lk_digit = lk_digit + 4'd1;
    if (lk_digit >= CodeLen || lk_digit == 4'd0) begin
      lk_digit = 4'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic clc_pkg::out_item_t predict_lock_reply(clc_pkg::in_item_t it);
    clc_pkg::out_item_t r;
    logic [15:0]        span;
    r = '0;
    r.reply_code = clc_pkg::REPLY_NONE;
    if (it.operation == clc_pkg::OP_BYTE) begin
      case (lk_mode)
        clc_pkg::LOCK_FIRST: begin
          if (lk_take_digit(it.data_byte, 1'b1, 1'b0)) begin
            lk_mode     = clc_pkg::LOCK_SECOND;
            lk_mismatch = 1'b0;
          end
        end
        clc_pkg::LOCK_SECOND: begin
          if (lk_take_digit(it.data_byte, 1'b0, 1'b0)) begin
            if (lk_mismatch) begin
              r.reply_code = clc_pkg::REPLY_DIFFER;
              lk_mode      = clc_pkg::LOCK_FIRST;
              lk_mismatch  = 1'b0;
            end else begin
              r.reply_code = clc_pkg::REPLY_SAME;
              lk_code      = lk_entry;
              lk_to_verify();
            end
          end
        end
        clc_pkg::LOCK_VERIFY: begin
          if (lk_take_digit(it.data_byte, 1'b0, 1'b1)) begin
            if (lk_mismatch) begin
              r.reply_code = clc_pkg::REPLY_NOMATCH;
              lk_mismatch  = 1'b0;
              lk_tries     = lk_tries + 4'd1;
              if (lk_tries >= set_max_tries) lk_mode = clc_pkg::LOCK_ALARM_OPTION;
            end else begin
              r.reply_code = clc_pkg::REPLY_MATCH;
              lk_mode      = clc_pkg::LOCK_OPTION;
            end
          end
        end
        clc_pkg::LOCK_OPTION: begin
          // Any byte consumes the option; only the two commands lead anywhere.
          lk_to_verify();
          if (it.data_byte == clc_pkg::CMD_OPEN_DOOR) begin
            lk_mode = clc_pkg::LOCK_MOTOR;
          end else if (it.data_byte == clc_pkg::CMD_CHANGE_CODE) begin
            lk_mode = clc_pkg::LOCK_FIRST;
          end
        end
        clc_pkg::LOCK_ALARM_OPTION: begin
          lk_to_verify();
          if (it.data_byte == clc_pkg::CMD_WRONG_CODE) lk_mode = clc_pkg::LOCK_ALARM;
        end
        clc_pkg::LOCK_MOTOR, clc_pkg::LOCK_ALARM: ;
        default: begin
          lk_mode     = clc_pkg::LOCK_FIRST;
          lk_digit    = 4'd0;
          lk_mismatch = 1'b0;
        end
      endcase
    end else if (lk_mode == clc_pkg::LOCK_MOTOR) begin
      // A zero duration ends the phase on its first tick, as the compare shows.
      span = (lk_motor_phase == 2'd1) ? set_hold : set_rotate;
      lk_phase_ticks = lk_phase_ticks + 16'd1;
      if (lk_phase_ticks >= span) begin
        lk_phase_ticks = 16'd0;
        if (lk_motor_phase >= 2'd2) lk_to_verify();
        else lk_motor_phase = lk_motor_phase + 2'd1;
      end
    end else if (lk_mode == clc_pkg::LOCK_ALARM) begin
      lk_phase_ticks = lk_phase_ticks + 16'd1;
      if (lk_phase_ticks >= set_alarm) lk_to_verify();
    end
    r.motor_drive = clc_pkg::DRIVE_STOP;
    if (lk_mode == clc_pkg::LOCK_MOTOR) begin
      if (lk_motor_phase == 2'd0) r.motor_drive = clc_pkg::DRIVE_CW;
      else if (lk_motor_phase == 2'd2) r.motor_drive = clc_pkg::DRIVE_CCW;
    end
    r.alarm_on  = (lk_mode == clc_pkg::LOCK_ALARM);
    r.lock_mode = lk_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic script_row_t free_row(logic op, logic [7:0] b);
    script_row_t r;
    r = '0;
    r.stim.operation = op;
    r.stim.data_byte = b;
    return r;
  endfunction

  function automatic script_row_t fixed_row(logic op, logic [7:0] b, logic [2:0] reply,
                                            logic [2:0] mode);
    script_row_t r;
    r = free_row(op, b);
    r.pinned           = 1'b1;
    r.want.reply_code  = reply;
    r.want.motor_drive = clc_pkg::DRIVE_STOP;
    r.want.alarm_on    = 1'b0;
    r.want.lock_mode   = mode;
    return r;
  endfunction

  // Digits lean toward the extremes and the command values.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return clc_pkg::CMD_OPEN_DOOR;
      3:       return clc_pkg::CMD_CHANGE_CODE;
      4:       return clc_pkg::CMD_WRONG_CODE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Picks the next keypad item from the predicted mode: mostly well-formed entries and
  // commands with random content, some wrong entries, and a little noise everywhere.
  function automatic clc_pkg::in_item_t next_keypad_item();
    clc_pkg::in_item_t it;
    int unsigned       roll;
    int unsigned       slot;
    roll = $urandom_range(0, 99);
    it.operation = clc_pkg::OP_BYTE;
    it.data_byte = any_byte();
    if (roll < 5) begin
      it.operation = ($urandom_range(0, 1) != 0) ? clc_pkg::OP_TICK : clc_pkg::OP_BYTE;
      return it;
    end
    case (lk_mode)
      clc_pkg::LOCK_FIRST, clc_pkg::LOCK_SECOND, clc_pkg::LOCK_VERIFY: begin
        if (roll < 12) begin
          it.operation = clc_pkg::OP_TICK;
          return it;
        end
        if (lk_digit == 4'd0) begin
          for (int k = 0; k < CodeLen; k++) begin
            if (lk_mode == clc_pkg::LOCK_VERIFY) keyed_code[k] = lk_code[k];
            else if (lk_mode == clc_pkg::LOCK_SECOND) keyed_code[k] = lk_entry[k];
            else keyed_code[k] = any_byte();
          end
          // Spoil one digit of a repeat or a check now and then.
          if (lk_mode != clc_pkg::LOCK_FIRST &&
              $urandom_range(0, 99) < ((lk_mode == clc_pkg::LOCK_VERIFY) ? 50 : 30)) begin
            slot = $urandom_range(0, CodeLen - 1);
            keyed_code[slot] = keyed_code[slot] ^ (8'd1 << $urandom_range(0, 7));
          end
        end
        it.data_byte = keyed_code[lk_digit];
      end
      clc_pkg::LOCK_OPTION: begin
        if (roll < 55) it.data_byte = clc_pkg::CMD_OPEN_DOOR;
        else if (roll < 80) it.data_byte = clc_pkg::CMD_CHANGE_CODE;
      end
      clc_pkg::LOCK_ALARM_OPTION: begin
        if (roll < 75) it.data_byte = clc_pkg::CMD_WRONG_CODE;
      end
      default: begin
        if (roll < 90) it.operation = clc_pkg::OP_TICK;
      end
    endcase
    return it;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  // Offers one item from a falling edge, waits for it to be taken, records the
  // expected result and returns on the next falling edge with valid still high.
  task automatic feed(input clc_pkg::in_item_t it, input logic pinned,
                      input clc_pkg::out_item_t want);
    clc_pkg::out_item_t guess;
    logic [2:0]         was;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    was   = lk_mode;
    guess = predict_lock_reply(it);
    pending_replies.push_back(pinned ? want : guess);
    sent++;
    if (lk_mode == clc_pkg::LOCK_MOTOR && was != clc_pkg::LOCK_MOTOR) door_runs++;
    if (lk_mode == clc_pkg::LOCK_ALARM && was != clc_pkg::LOCK_ALARM) alarms++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int unsigned n;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    n = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [clc_pkg::CfgIdxW-1:0] idx,
                           input logic [clc_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      clc_pkg::CFG_ROTATE_TICKS: set_rotate    = val;
      clc_pkg::CFG_HOLD_TICKS:   set_hold      = val;
      clc_pkg::CFG_ALARM_TICKS:  set_alarm     = val;
      clc_pkg::CFG_MAX_TRIALS:   set_max_tries = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only with the block idle; the lock keeps its mode across the change.
  task automatic load_settings(input logic [15:0] rot, input logic [15:0] hold,
                               input logic [15:0] alarm, input logic [15:0] tries);
    settle();
    write_reg(clc_pkg::CFG_ROTATE_TICKS, rot);
    write_reg(clc_pkg::CFG_HOLD_TICKS, hold);
    write_reg(clc_pkg::CFG_ALARM_TICKS, alarm);
    write_reg(clc_pkg::CFG_MAX_TRIALS, tries);
    cfg_we <= 1'b0;
  endtask

  // Sends quota random keypad items; the ones that the lock acts on are tallied apart.
  // With squeeze set, the receiver is asked for one long hold-off early in the stretch.
  task automatic drive_random(input int unsigned quota, input bit squeeze);
    int unsigned       done;
    clc_pkg::in_item_t it;
    bit                idle_item;
    done = 0;
    while (done < quota) begin
      it = next_keypad_item();
      // Ticks outside the timed modes and bytes inside them change nothing.
      idle_item = (it.operation == clc_pkg::OP_TICK) !=
                  (lk_mode == clc_pkg::LOCK_MOTOR || lk_mode == clc_pkg::LOCK_ALARM);
      feed(it, 1'b0, '0);
      done++;
      if (!idle_item) counted++;
      if (squeeze && done == 20) hold_due = 1'b1;
      sender_gap();
    end
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    lk_mode        = clc_pkg::LOCK_FIRST;
    lk_digit       = 4'd0;
    lk_mismatch    = 1'b0;
    lk_tries       = 4'd0;
    lk_motor_phase = 2'd0;
    lk_phase_ticks = 16'd0;
    set_rotate     = clc_pkg::RotateTicksRst;
    set_hold       = clc_pkg::HoldTicksRst;
    set_alarm      = clc_pkg::AlarmTicksRst;
    set_max_tries  = clc_pkg::MaxTrialsRst;
    keyed_code     = '{default: 8'h00};

    // Opening script at the reset settings: an idle tick, a code keyed twice, another idle
    // tick, a wrong check, a right check, and an unknown command in place of an option.
    opening = '{
      fixed_row(clc_pkg::OP_TICK, 8'h00, clc_pkg::REPLY_NONE, clc_pkg::LOCK_FIRST),
      free_row(clc_pkg::OP_BYTE, 8'h00), free_row(clc_pkg::OP_BYTE, 8'hFF),
      free_row(clc_pkg::OP_BYTE, 8'h80), free_row(clc_pkg::OP_BYTE, 8'h01),
      fixed_row(clc_pkg::OP_BYTE, 8'h7F, clc_pkg::REPLY_NONE, clc_pkg::LOCK_SECOND),
      free_row(clc_pkg::OP_BYTE, 8'h00), free_row(clc_pkg::OP_BYTE, 8'hFF),
      free_row(clc_pkg::OP_BYTE, 8'h80), free_row(clc_pkg::OP_BYTE, 8'h01),
      fixed_row(clc_pkg::OP_BYTE, 8'h7F, clc_pkg::REPLY_SAME, clc_pkg::LOCK_VERIFY),
      fixed_row(clc_pkg::OP_TICK, 8'hFF, clc_pkg::REPLY_NONE, clc_pkg::LOCK_VERIFY),
      free_row(clc_pkg::OP_BYTE, 8'h00), free_row(clc_pkg::OP_BYTE, 8'hFF),
      free_row(clc_pkg::OP_BYTE, 8'h80), free_row(clc_pkg::OP_BYTE, 8'h01),
      fixed_row(clc_pkg::OP_BYTE, 8'h7E, clc_pkg::REPLY_NOMATCH, clc_pkg::LOCK_VERIFY),
      free_row(clc_pkg::OP_BYTE, 8'h00), free_row(clc_pkg::OP_BYTE, 8'hFF),
      free_row(clc_pkg::OP_BYTE, 8'h80), free_row(clc_pkg::OP_BYTE, 8'h01),
      fixed_row(clc_pkg::OP_BYTE, 8'h7F, clc_pkg::REPLY_MATCH, clc_pkg::LOCK_OPTION),
      fixed_row(clc_pkg::OP_BYTE, 8'hAA, clc_pkg::REPLY_NONE, clc_pkg::LOCK_VERIFY)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[i]) begin
      feed(opening[i].stim, opening[i].pinned, opening[i].want);
      sender_gap();
    end
    drive_random(150, 1'b1);

    // Shortest phases and a lockout after a single wrong entry.
    load_settings(16'd1, 16'd1, 16'd1, 16'd1);
    drive_random(120, 1'b0);
    // Zero durations and zero allowed trials.
    load_settings(16'd0, 16'd0, 16'd0, 16'd0);
    drive_random(100, 1'b0);
    // Full-scale settings; the upper bits of the trial count are dropped.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_random(60, 1'b0);
    load_settings(16'd6, 16'd2, 16'd9, 16'd2);
    drive_random(200, 1'b1);

    settle();
    repeat (8) @(negedge clk);

    $display("Sent %0d items (%0d acted on) over five register settings, zero to full scale.",
             sent, counted);
    $display("Compared %0d results; the door opened %0d times and the alarm sounded %0d times.",
             results_seen, door_runs, alarms);
    if (errs == 0 && pending_replies.size() == 0) begin
      $display("combination_lock_controller_unit regression: pass");
    end else begin
      $display("combination_lock_controller_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls, stretches of steady acceptance, and the long hold-off that fills
  // the output buffer so that input ready has to drop.
  initial begin : result_sink
    int unsigned stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 79) == 0) rx_steady = !rx_steady;
      if (hold_due) begin
        hold_due   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_span();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_replies.size() == 0) begin
        $error("result item with no item outstanding: %h", out_data);
        errs++;
      end else begin
        oldest = pending_replies.pop_front();
        if (out_data.reply_code != oldest.reply_code) begin
          $error("reply_code: expected %0d, got %0d", oldest.reply_code, out_data.reply_code);
          errs++;
        end
        if (out_data.motor_drive != oldest.motor_drive) begin
          $error("motor_drive: expected %0d, got %0d", oldest.motor_drive, out_data.motor_drive);
          errs++;
        end
        if (out_data.alarm_on != oldest.alarm_on) begin
          $error("alarm_on: expected %0d, got %0d", oldest.alarm_on, out_data.alarm_on);
          errs++;
        end
        if (out_data.lock_mode != oldest.lock_mode) begin
          $error("lock_mode: expected %0d, got %0d", oldest.lock_mode, out_data.lock_mode);
          errs++;
        end
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  initial begin : stall_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("combination_lock_controller_unit regression: fail");
    $finish;
  end

endmodule

@@ combination_lock_controller_unit.f @@
rtl/clc_pkg.sv
rtl/clc_code_ram.sv
rtl/combination_lock_controller_unit.sv
tb/sv/combination_lock_controller_unit_tb.sv
